[src/separable_3x3_filter_mirror_edges_macros.svh]
// Assertion macros shared by the checker.
`ifndef SEPARABLE_3X3_FILTER_MIRROR_EDGES_MACROS_SVH
`define SEPARABLE_3X3_FILTER_MIRROR_EDGES_MACROS_SVH

// Implication in the same cycle
`define SF3_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle
`define SF3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/sf3_pkg.sv]
package sf3_pkg;

	// Sizes
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 10;
	localparam int DIM_W      = 11;
	localparam int CMP_W      = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
	localparam int SAMP_W     = 16;
	localparam int TAP_W      = 16;
	localparam int FILT_W     = 20;
	localparam int POS_W      = 10;
	localparam int ACC_W      = 36;
	localparam int OUT_DATA_W = 40;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	// Register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_TAP_0   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_TAP_1   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_TAP_2   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HORIZ_TAP_0  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HORIZ_TAP_1  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HORIZ_TAP_2  = 3'd7;

	// Reset values
	localparam logic [DIM_W-1:0] RST_DIM      = 11'd256;
	localparam logic [TAP_W-1:0] RST_TAP_SIDE = 16'd2731;
	localparam logic [TAP_W-1:0] RST_TAP_MID  = 16'd5461;

	// Effective frame size, already clamped
	typedef struct packed {
		logic [CMP_W-1:0] width;
		logic [CMP_W-1:0] height;
	} dims_t;

	typedef struct packed {
		logic [2:0][TAP_W-1:0] vtap;
		logic [2:0][TAP_W-1:0] htap;
	} taps_t;

	// One output pixel to compute: mirrored 3x3 neighborhood, row-major
	typedef struct packed {
		logic [8:0][SAMP_W-1:0] pix;
		logic [POS_W-1:0]       row;
		logic [POS_W-1:0]       col;
		logic                   last;
	} job_t;

endpackage

[src/sf3_front.sv]
module sf3_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,
	input  sf3_pkg::dims_t   dims,
	output logic             push,
	output sf3_pkg::job_t    job,
	input  logic             full
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_LOAD = 3'b010,
		F_EMIT = 3'b100
	} fstate_t;

	localparam int CW = sf3_pkg::COL_W;
	localparam int RW = sf3_pkg::ROW_W;
	localparam int MW = sf3_pkg::CMP_W;
	localparam int SW = sf3_pkg::SAMP_W;

	fstate_t state_q;
	logic [RW-1:0] row_q, r_q;
	logic [CW-1:0] col_q, c_q, wm1_q;
	logic [SW-1:0] samp_q;
	logic [2*SW-1:0] rd_q;
	logic [2*SW-1:0] line_mem [sf3_pkg::MAX_WIDTH];
	logic [2:0][2:0][SW-1:0] win_q;
	logic [3:0] en_q;
	logic [1:0] idx_q;

	logic accept;
	logic [CW-1:0] c_cur, c_m1;
	logic [RW-1:0] r_cur;
	logic [MW-1:0] c_inc, r_inc, w_m1, h_m1;
	logic r_ge1, c_ge1, c_end, r_end;
	logic [3:0] above;
	logic pass_b, right_job, adv;
	logic [2:0][1:0] rs, cs;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == F_IDLE);

	// Position of this request, wrapped if the frame size shrank
	always_comb begin
		c_cur = (MW'(col_q) >= dims.width)  ? '0 : col_q;
		r_cur = (MW'(row_q) >= dims.height) ? '0 : row_q;
		c_inc = MW'(c_cur) + MW'(1);
		r_inc = MW'(r_cur) + MW'(1);
		w_m1  = dims.width - MW'(1);
		h_m1  = dims.height - MW'(1);
	end

	// Line store: low half holds the older row, high half the newer row
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q   <= line_mem[c_cur];
			samp_q <= s_tdata;
		end
		if (state_q == F_LOAD) begin
			line_mem[c_q] <= {samp_q, rd_q[2*SW-1:SW]};
		end
	end

	// Window shift and new column
	always_ff @(posedge clk) begin
		if (state_q == F_LOAD) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= rd_q[SW-1:0];
			win_q[1][2] <= rd_q[2*SW-1:SW];
			win_q[2][2] <= samp_q;
		end
	end

	// Which of the up to four results this request produces
	always_comb begin
		r_ge1 = (r_q != '0);
		c_ge1 = (c_q != '0);
		c_end = (MW'(c_q) == w_m1);
		r_end = (MW'(r_q) == h_m1);
	end

	// Emit order: row above (left col, right edge), then last row (same)
	always_comb begin
		pass_b    = idx_q[1];
		right_job = idx_q[0];
		above     = en_q & ~((4'b0010 << idx_q) - 4'd1);
		adv       = (state_q == F_EMIT) && (!en_q[idx_q] || !full);
		push      = (state_q == F_EMIT) && en_q[idx_q] && !full;
		c_m1      = c_q - CW'(1);
		// mirrored row selection; top row at frame row 0 reflects to row 1
		if (pass_b) begin
			rs[0] = 2'd1; rs[1] = 2'd2; rs[2] = 2'd1;
		end else begin
			rs[0] = (r_q == RW'(1)) ? 2'd2 : 2'd0;
			rs[1] = 2'd1;
			rs[2] = 2'd2;
		end
		if (right_job) begin
			cs[0] = 2'd1; cs[1] = 2'd2; cs[2] = 2'd1;
		end else begin
			cs[0] = (c_q == CW'(1)) ? 2'd2 : 2'd0;
			cs[1] = 2'd1;
			cs[2] = 2'd2;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				job.pix[i*3+j] = win_q[rs[i]][cs[j]];
			end
		end
		job.row  = pass_b ? sf3_pkg::POS_W'(r_q) : sf3_pkg::POS_W'(r_q - RW'(1));
		job.col  = right_job ? sf3_pkg::POS_W'(wm1_q) : sf3_pkg::POS_W'(c_m1);
		job.last = (above == 4'd0);
	end

	// Sequencer and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			r_q     <= '0;
			c_q     <= '0;
			en_q    <= '0;
			idx_q   <= '0;
			wm1_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						r_q <= r_cur;
						c_q <= c_cur;
						if (c_inc >= dims.width) begin
							col_q <= '0;
							row_q <= (r_inc >= dims.height) ? '0 : r_inc[RW-1:0];
						end else begin
							col_q <= c_inc[CW-1:0];
							row_q <= r_cur;
						end
						state_q <= F_LOAD;
					end
				end
				F_LOAD: begin
					en_q[0] <= r_ge1 && c_ge1;
					en_q[1] <= r_ge1 && c_end;
					en_q[2] <= r_ge1 && r_end && c_ge1;
					en_q[3] <= r_ge1 && r_end && c_end;
					wm1_q   <= w_m1[CW-1:0];
					idx_q   <= '0;
					state_q <= (r_ge1 && (c_ge1 || c_end)) ? F_EMIT : F_IDLE;
				end
				F_EMIT: begin
					if (adv) begin
						if (above == 4'd0) begin
							state_q <= F_IDLE;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

[src/sf3_queue.sv]
module sf3_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sf3_pkg::job_t wr_job,
	output logic          full,
	input  logic          pop,
	output sf3_pkg::job_t head,
	output logic          empty
);

	localparam int PW = sf3_pkg::QPTR_W;
	localparam int NW = sf3_pkg::QCNT_W;

	sf3_pkg::job_t slot_q [sf3_pkg::QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [NW-1:0] cnt_q;

	assign full  = (cnt_q == NW'(sf3_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rp_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wr_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(sf3_pkg::QDEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(sf3_pkg::QDEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

endmodule

[src/sf3_back.sv]
module sf3_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sf3_pkg::taps_t                    taps,
	input  sf3_pkg::job_t                     head,
	input  logic                              empty,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sf3_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast
);

	typedef enum logic [3:0] {
		B_IDLE  = 4'b0001,
		B_RUN   = 4'b0010,
		B_DRAIN = 4'b0100,
		B_DONE  = 4'b1000
	} bstate_t;

	localparam int AW = sf3_pkg::ACC_W;
	localparam int FW = sf3_pkg::FILT_W;
	localparam int SW = sf3_pkg::SAMP_W;
	localparam int TW = sf3_pkg::TAP_W;

	bstate_t state_q;
	logic [1:0] ti_q, tj_q;
	logic [3:0] pidx;
	logic issue, load;

	logic signed [2*TW-1:0] vh_s1;
	logic [SW-1:0] x_s1;
	logic v_s1, first_s1, last_s1;
	logic signed [SW+TW-1:0] prod_s2;
	logic v_s2, first_s2, last_s2;
	logic signed [AW-1:0] acc_q;

	logic signed [2*TW:0] vh_rnd;
	logic signed [2*TW-14:0] k_wide;
	logic signed [TW-1:0] k_sat;
	logic signed [AW-1:0] acc_rnd;
	logic signed [AW-15:0] f_wide;
	logic signed [FW-1:0] f_sat;

	logic out_v_q, out_last_q;
	logic [sf3_pkg::OUT_DATA_W-1:0] out_data_q;

	assign issue = (state_q == B_RUN);
	assign load  = (state_q == B_DONE) && !out_v_q;
	assign pop   = load;
	assign pidx  = ({2'b00, ti_q} << 1) + {2'b00, ti_q} + {2'b00, tj_q};

	// Step 1: kernel coefficient product, sample pick
	always_ff @(posedge clk) begin
		vh_s1    <= $signed(taps.vtap[ti_q]) * $signed(taps.htap[tj_q]);
		x_s1     <= head.pix[pidx];
		first_s1 <= (ti_q == 2'd0) && (tj_q == 2'd0);
		last_s1  <= (ti_q == 2'd2) && (tj_q == 2'd2);
	end

	// Coefficient rounded to Q2.14, saturated to 16 bits
	always_comb begin
		vh_rnd = $signed({vh_s1[2*TW-1], vh_s1}) + $signed((2*TW+1)'(8192));
		k_wide = vh_rnd[2*TW:14];
		if (k_wide > $signed((2*TW-13)'(32767))) begin
			k_sat = 16'sh7FFF;
		end else if (k_wide < -$signed((2*TW-13)'(32768))) begin
			k_sat = 16'sh8000;
		end else begin
			k_sat = k_wide[TW-1:0];
		end
	end

	// Step 2: sample times coefficient
	always_ff @(posedge clk) begin
		prod_s2  <= $signed(x_s1) * k_sat;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
	end

	// Step 3: accumulate the nine terms
	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= first_s2 ? AW'(prod_s2) : acc_q + AW'(prod_s2);
		end
	end

	// Final rounding to six fraction bits and saturation
	always_comb begin
		acc_rnd = acc_q + AW'(8192);
		f_wide  = acc_rnd[AW-1:14];
		if (f_wide > $signed((AW-14)'(524287))) begin
			f_sat = 20'sh7FFFF;
		end else if (f_wide < -$signed((AW-14)'(524288))) begin
			f_sat = 20'sh80000;
		end else begin
			f_sat = f_wide[FW-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= {head.col, head.row, f_sat};
			out_last_q <= head.last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ti_q    <= '0;
			tj_q    <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					ti_q <= '0;
					tj_q <= '0;
					if (!empty) begin
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					if (tj_q == 2'd2) begin
						tj_q <= '0;
						ti_q <= ti_q + 2'd1;
					end else begin
						tj_q <= tj_q + 2'd1;
					end
					if ((ti_q == 2'd2) && (tj_q == 2'd2)) begin
						state_q <= B_DRAIN;
					end
				end
				B_DRAIN: begin
					if (v_s2 && last_s2) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (load) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

[src/separable_3x3_filter_mirror_edges.sv]
// Separable 3x3 filter with mirrored edges.
// Input stream (s_*): one signed Q10.6 sample per request, raster order.
// Output stream (m_*): filtered pixel with its row and column; tlast marks
// the last result caused by one input sample. Each input gives 0 to 4
// results: output pixel (r,c) appears once sample (r+1,c+1) is in, the
// right edge and the last row are produced early by reflection.
// Config: write frame size and the six Q2.14 taps through cfg_we/index/data
// while the block is idle; they take effect on the next sample.
// Path: an accepted sample passes the front end's load and emit states into the
// job queue; the back end then steps through its run, drain and done states and
// loads the result into the output register. The front end takes no new sample
// until all jobs of the last one are queued, and waits while the queue is full;
// each result passes the multiply-accumulate unit as nine coefficient and sample
// products through one pair of multipliers, one result at a time. A two-entry
// job queue lets the front end take new samples while results are still computed.
// Reset: position counters go to row 0, column 0, registers to defaults
// (256x256, taps 2731/5461/2731); the line store holds no valid data.
// Stall: with m_tready low the result stays in the output register, the
// queue fills, and then s_tready stays low until space frees up.
module separable_3x3_filter_mirror_edges (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [19:0] filtered, [29:20] out_row, [39:30] out_col
	output logic        m_tlast,   // run_last
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int MW = sf3_pkg::CMP_W;

	logic [sf3_pkg::DIM_W-1:0] width_q, height_q;
	logic [2:0][sf3_pkg::TAP_W-1:0] vtap_q, htap_q;
	logic [MW-1:0] fw, fh;

	sf3_pkg::dims_t dims;
	sf3_pkg::taps_t taps;
	sf3_pkg::job_t  fr_job, q_head;
	logic q_push, q_full, q_pop, q_empty;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sf3_pkg::RST_DIM;
			height_q <= sf3_pkg::RST_DIM;
			vtap_q   <= {sf3_pkg::RST_TAP_SIDE, sf3_pkg::RST_TAP_MID, sf3_pkg::RST_TAP_SIDE};
			htap_q   <= {sf3_pkg::RST_TAP_SIDE, sf3_pkg::RST_TAP_MID, sf3_pkg::RST_TAP_SIDE};
		end else if (cfg_we) begin
			case (cfg_index)
				sf3_pkg::REG_FRAME_WIDTH:  width_q   <= cfg_data[sf3_pkg::DIM_W-1:0];
				sf3_pkg::REG_FRAME_HEIGHT: height_q  <= cfg_data[sf3_pkg::DIM_W-1:0];
				sf3_pkg::REG_VERT_TAP_0:   vtap_q[0] <= cfg_data;
				sf3_pkg::REG_VERT_TAP_1:   vtap_q[1] <= cfg_data;
				sf3_pkg::REG_VERT_TAP_2:   vtap_q[2] <= cfg_data;
				sf3_pkg::REG_HORIZ_TAP_0:  htap_q[0] <= cfg_data;
				sf3_pkg::REG_HORIZ_TAP_1:  htap_q[1] <= cfg_data;
				sf3_pkg::REG_HORIZ_TAP_2:  htap_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Clamp frame size to the supported range
	always_comb begin
		fw = MW'(width_q);
		fh = MW'(height_q);
		if (fw < MW'(2)) begin
			dims.width = MW'(2);
		end else if (fw > MW'(sf3_pkg::MAX_WIDTH)) begin
			dims.width = MW'(sf3_pkg::MAX_WIDTH);
		end else begin
			dims.width = fw;
		end
		if (fh < MW'(2)) begin
			dims.height = MW'(2);
		end else if (fh > MW'(sf3_pkg::MAX_HEIGHT)) begin
			dims.height = MW'(sf3_pkg::MAX_HEIGHT);
		end else begin
			dims.height = fh;
		end
		taps.vtap = vtap_q;
		taps.htap = htap_q;
	end

	sf3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.dims     (dims),
		.push     (q_push),
		.job      (fr_job),
		.full     (q_full)
	);

	sf3_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (fr_job),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (q_empty)
	);

	sf3_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.taps     (taps),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[src/sf3_checker.sv]
`include "separable_3x3_filter_mirror_edges_macros.svh"

module sf3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	logic s_req, m_req, m_stall;
	logic [40:0] m_word;

	assign s_req   = s_tvalid && s_tready;
	assign m_req   = m_tvalid && m_tready;
	assign m_stall = m_tvalid && !m_tready;
	assign m_word  = {m_tlast, m_tdata};

	// A stalled result holds
	`SF3_ASSERT_NEXT(a_out_hold, clk, arst_n, m_stall, m_tvalid && $stable(m_word), "held result changed")

	// The line store write cycle follows every accepted sample
	`SF3_ASSERT_NEXT(a_in_gap, clk, arst_n, s_req, !s_tready, "ready right after a sample")

	// The output register is only refilled once empty
	`SF3_ASSERT_NEXT(a_out_gap, clk, arst_n, m_req, !m_tvalid, "result refilled at once")

	// Idle reset state: nothing to send right after reset release
	`SF3_ASSERT_NOW(a_rst_idle, clk, arst_n, $rose(arst_n), !m_tvalid, "result at reset release")

endmodule

bind separable_3x3_filter_mirror_edges sf3_checker u_sf3_checker (.*);

[tb/sf3_result_checker.sv]
// Watches the sample, result and register-write ports of the separable 3x3 filter.
// Keeps its own copy of the frame position, line store, window and taps,
// predicts the results of every accepted sample, and compares each accepted
// result with the oldest prediction.
module sf3_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] sample
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,    // [19:0] filtered, [29:20] out_row, [39:30] out_col
	input  logic        m_tlast,    // run_last
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [19:0] filtered;
		logic [9:0]  row;
		logic [9:0]  col;
		logic        last;
	} px_result_t;

	// Shadow of the block's state and registers
	logic [10:0]        width_reg, height_reg;
	logic signed [15:0] vt [3];
	logic signed [15:0] ht [3];
	logic signed [15:0] line_mem [2 * sf3_pkg::MAX_WIDTH];
	logic signed [15:0] win [3][3];
	int unsigned        row_pos, col_pos;
	px_result_t         pending_px [$];

	// Kernel taps are vt[i]*ht[j] rounded to Q2.14 and clipped to 16 bits;
	// rs/cs pick the window row/column each tap lands on (mirror at edges).
	function automatic logic [19:0] window_response(input logic [2:0][1:0] rs,
			input logic [2:0][1:0] cs);
		longint acc, coef;
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				coef = (longint'(vt[i]) * longint'(ht[j]) + 8192) >>> 14;
				if (coef > 32767)
					coef = 32767;
				else if (coef < -32768)
					coef = -32768;
				acc += longint'(win[rs[i]][cs[j]]) * coef;
			end
		end
		acc = (acc + 8192) >>> 14;
		if (acc > 524287)
			acc = 524287;
		else if (acc < -524288)
			acc = -524288;
		return acc[19:0];
	endfunction

	// Results of one output row for the current column: the pixel left of it,
	// and the right-edge pixel early when this is the last column.
	task automatic emit_row(input int unsigned orow, input logic [2:0][1:0] rs,
			input int unsigned c, input int unsigned w);
		px_result_t px;
		px.last = 1'b0;
		px.row  = 10'(orow);
		if (c >= 1) begin
			px.filtered = window_response(rs, {2'd2, 2'd1, (c == 1) ? 2'd2 : 2'd0});
			px.col      = 10'(c - 1);
			pending_px  = {pending_px, px};
		end
		if (c == w - 1) begin
			px.filtered = window_response(rs, {2'd1, 2'd2, 2'd1});
			px.col      = 10'(w - 1);
			pending_px  = {pending_px, px};
		end
	endtask

	task automatic absorb_sample(input logic signed [15:0] s);
		int unsigned w, h, r, c, first;
		w = (width_reg < 2) ? 2 : width_reg;
		if (w > sf3_pkg::MAX_WIDTH)
			w = sf3_pkg::MAX_WIDTH;
		h = (height_reg < 2) ? 2 : height_reg;
		if (h > sf3_pkg::MAX_HEIGHT)
			h = sf3_pkg::MAX_HEIGHT;
		// size may have shrunk below the position since the last sample
		if (col_pos >= w)
			col_pos = 0;
		if (row_pos >= h)
			row_pos = 0;
		r = row_pos;
		c = col_pos;

		// slide window, pull the new column from the two stored rows
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = line_mem[c];
		win[1][2] = line_mem[sf3_pkg::MAX_WIDTH + c];
		win[2][2] = s;
		line_mem[c]                      = line_mem[sf3_pkg::MAX_WIDTH + c];
		line_mem[sf3_pkg::MAX_WIDTH + c] = s;

		// row above is finished now; last row is finished early by reflection
		first = pending_px.size();
		if (r >= 1) begin
			emit_row(r - 1, {2'd2, 2'd1, (r == 1) ? 2'd2 : 2'd0}, c, w);
			if (r == h - 1)
				emit_row(r, {2'd1, 2'd2, 2'd1}, c, w);
		end
		if (pending_px.size() > first)
			pending_px[pending_px.size() - 1].last = 1'b1;

		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	task automatic check_result();
		px_result_t want, got;
		got.filtered = m_tdata[19:0];
		got.row      = m_tdata[29:20];
		got.col      = m_tdata[39:30];
		got.last     = m_tlast;
		if (pending_px.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected result: filtered %0d row %0d col %0d last %0b",
					$signed(got.filtered), got.row, got.col, got.last);
			mismatches++;
		end else begin
			want = pending_px.pop_front();
			if (got.filtered !== want.filtered || got.row !== want.row ||
					got.col !== want.col || got.last !== want.last) begin
				if (mismatches < 10)
					$display({"result mismatch: expected filtered %0d row %0d col %0d ",
						"last %0b, got filtered %0d row %0d col %0d last %0b"},
						$signed(want.filtered), want.row, want.col, want.last,
						$signed(got.filtered), got.row, got.col, got.last);
				mismatches++;
			end
		end
	endtask

	// Track register writes, results and sample requests at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = sf3_pkg::RST_DIM;
			height_reg = sf3_pkg::RST_DIM;
			vt[0] = sf3_pkg::RST_TAP_SIDE;
			vt[1] = sf3_pkg::RST_TAP_MID;
			vt[2] = sf3_pkg::RST_TAP_SIDE;
			ht[0] = sf3_pkg::RST_TAP_SIDE;
			ht[1] = sf3_pkg::RST_TAP_MID;
			ht[2] = sf3_pkg::RST_TAP_SIDE;
			for (int k = 0; k < 2 * sf3_pkg::MAX_WIDTH; k++)
				line_mem[k] = '0;
			for (int k = 0; k < 9; k++)
				win[k / 3][k % 3] = '0;
			row_pos = 0;
			col_pos = 0;
			pending_px.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sf3_pkg::REG_FRAME_WIDTH:  width_reg  = cfg_data[10:0];
					sf3_pkg::REG_FRAME_HEIGHT: height_reg = cfg_data[10:0];
					sf3_pkg::REG_VERT_TAP_0:   vt[0] = cfg_data;
					sf3_pkg::REG_VERT_TAP_1:   vt[1] = cfg_data;
					sf3_pkg::REG_VERT_TAP_2:   vt[2] = cfg_data;
					sf3_pkg::REG_HORIZ_TAP_0:  ht[0] = cfg_data;
					sf3_pkg::REG_HORIZ_TAP_1:  ht[1] = cfg_data;
					sf3_pkg::REG_HORIZ_TAP_2:  ht[2] = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				absorb_sample(s_tdata);
		end
		outstanding = pending_px.size();
	end

endmodule

[tb/separable_3x3_filter_mirror_edges_tb.sv]
module separable_3x3_filter_mirror_edges_tb;

	localparam int LONG_HOLD = 300;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;   // [15:0] sample
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;          // [19:0] filtered, [29:20] out_row, [39:30] out_col
	logic        m_tlast;          // run_last
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = sf3_pkg::REG_FRAME_WIDTH;
	logic [15:0] cfg_data  = '0;
	int          mismatches, outstanding;

	int          src_idle     = 0;
	int          sink_idle    = 0;
	int          holds_asked  = 0;
	int          holds_served = 0;
	int          hold_left    = 0;
	logic [15:0] pix_q [$];

	separable_3x3_filter_mirror_edges dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	sf3_result_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Result side: random back-pressure, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			m_tready     <= 1'b0;
			hold_left    <= LONG_HOLD;
			holds_served <= holds_served + 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= sink_idle);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_size(input logic [15:0] w_word, input logic [15:0] h_word);
		write_reg(sf3_pkg::REG_FRAME_WIDTH, w_word);
		write_reg(sf3_pkg::REG_FRAME_HEIGHT, h_word);
	endtask

	task automatic load_taps(input logic [15:0] v0, v1, v2, h0, h1, h2);
		write_reg(sf3_pkg::REG_VERT_TAP_0, v0);
		write_reg(sf3_pkg::REG_VERT_TAP_1, v1);
		write_reg(sf3_pkg::REG_VERT_TAP_2, v2);
		write_reg(sf3_pkg::REG_HORIZ_TAP_0, h0);
		write_reg(sf3_pkg::REG_HORIZ_TAP_1, h1);
		write_reg(sf3_pkg::REG_HORIZ_TAP_2, h2);
	endtask

	// Frame size as the block uses it (register value clamped)
	function automatic int unsigned eff_dim(input logic [15:0] word, input int unsigned hi);
		int unsigned v;
		v = word[10:0];
		return (v < 2) ? 2 : ((v > hi) ? hi : v);
	endfunction

	// Laws-style vector entries, extremes, or anything
	function automatic logic [15:0] pick_tap();
		case ($urandom_range(0, 7))
			0: return 16'd2731;    // 1/6
			1: return 16'd5461;    // 2/6
			2: return 16'hE000;    // -1/2
			3: return 16'h2000;    // +1/2
			4: return 16'h0000;
			5: return 16'h8000;
			6: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 511)) - 16'd256;   // near zero
			1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_frame(input int unsigned w, input int unsigned h);
		repeat (w * h) pix_q = {pix_q, pick_sample()};
	endtask

	// Offer every queued sample; valid holds until the request is taken
	task automatic send_all();
		while (pix_q.size() != 0) begin
			if ($urandom_range(0, 99) < src_idle) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= pix_q.pop_front();
				@(posedge clk);
				while (!s_tready) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
	endtask

	// All results in, then time for samples that cause none to clear the pipe
	task automatic wait_idle();
		do @(posedge clk); while (outstanding != 0);
		repeat (32) @(posedge clk);
	endtask

	initial begin
		logic [15:0] w_word, h_word;
		int          sent;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle  = 32;
		sink_idle <= 62;

		// Smallest frame (width with junk upper bits, height zero), clipped
		// coefficients of both signs; the last sample gives four results
		set_size(16'hF802, 16'h0000);
		load_taps(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
		pix_q = {16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF};
		send_all();
		wait_idle();

		// Response saturation high, then low
		load_taps(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		pix_q = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h8000, 16'h8000, 16'h8000, 16'h8000};
		send_all();
		wait_idle();

		// Size shrinks mid-frame: column wraps, later row wraps
		set_size(16'd4, 16'd4);
		load_taps(16'd2731, 16'd5461, 16'd2731, 16'hE000, 16'h0000, 16'h2000);
		queue_frame(6, 1);
		send_all();
		wait_idle();
		write_reg(sf3_pkg::REG_FRAME_WIDTH, 16'h3802);
		queue_frame(4, 1);
		send_all();
		wait_idle();
		write_reg(sf3_pkg::REG_FRAME_HEIGHT, 16'd2);
		queue_frame(4, 1);
		send_all();
		wait_idle();

		// Random frames under three idling patterns
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin src_idle = 32; sink_idle <= 62; end
				1: begin src_idle = 62; sink_idle <= 32; end
				default: begin src_idle = 0; sink_idle <= 0; end
			endcase
			sent = 0;
			while (sent < 45) begin
				w_word = {5'($urandom), 11'($urandom_range(0, 9))};
				h_word = {5'($urandom), 11'($urandom_range(0, 6))};
				set_size(w_word, h_word);
				load_taps(pick_tap(), pick_tap(), pick_tap(), pick_tap(), pick_tap(),
					pick_tap());
				repeat ($urandom_range(1, 2))
					queue_frame(eff_dim(w_word, sf3_pkg::MAX_WIDTH),
						eff_dim(h_word, sf3_pkg::MAX_HEIGHT));
				sent += pix_q.size();
				send_all();
				wait_idle();
			end
		end

		// Result side holds off while samples keep coming: input must stall
		set_size(16'd8, 16'd6);
		load_taps(pick_tap(), pick_tap(), pick_tap(), pick_tap(), pick_tap(), pick_tap());
		queue_frame(8, 6);
		holds_asked <= holds_asked + 1;
		send_all();
		wait_idle();

		// Out-of-range sizes clamp: part of a widest row, then width zero with
		// an oversized height wraps the column, then a small frame wraps the row
		set_size(16'h07FF, 16'd2);
		load_taps(pick_tap(), pick_tap(), pick_tap(), pick_tap(), pick_tap(), pick_tap());
		queue_frame(8, 1);
		send_all();
		wait_idle();
		set_size(16'hF800, 16'd1500);
		queue_frame(2, 3);
		send_all();
		wait_idle();
		set_size(16'd4, 16'd2);
		queue_frame(4, 2);
		send_all();
		wait_idle();

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
